// ===== hdl/sliding_window_average_defines.svh =====
// Assertion macros for the sliding window average block.
// Modules that use them need signals named clk and rst_n.
`ifndef SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`ifndef SYNTHESIS
`define SWA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SWA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWA_ASSERT_IMP(label, ante, cons, msg)
`define SWA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/swa_pkg.sv =====
// Shared widths, constants and controller/datapath interface types
// for the sliding window average block. No dependencies.
`default_nettype none

package swa_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 7;
    localparam int FRAC_W   = 8;
    localparam int AVG_W    = 40;
    // running total holds up to 127 samples of 32 bits
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int DVD_W    = SUM_W + FRAC_W;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd3;

    typedef struct packed {
        logic capture;
        logic cfg_write;
        logic update;
        logic div_start;
        logic load_out;
    } swa_cmd_t;

    typedef struct packed {
        logic div_done;
    } swa_sts_t;

endpackage

`default_nettype wire

// ===== hdl/swa_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Depends on swa_pkg for the dividend and divisor widths.
`default_nettype none

module swa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [swa_pkg::DVD_W-1:0]  dividend,
    input  wire logic [swa_pkg::CNT_W-1:0]  divisor,
    output logic                            done,
    output logic [swa_pkg::DVD_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(swa_pkg::DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(swa_pkg::DVD_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [swa_pkg::DVD_W-1:0]     dvd_reg;
    logic [swa_pkg::CNT_W-1:0]     rem_reg;
    logic [swa_pkg::CNT_W-1:0]     dsr_reg;

    logic [swa_pkg::CNT_W:0]       rem_shift;
    logic [swa_pkg::CNT_W:0]       rem_diff;
    logic                          q_bit;

    assign rem_shift = {rem_reg, dvd_reg[swa_pkg::DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign q_bit     = (rem_shift >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits fill in from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[swa_pkg::DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[swa_pkg::CNT_W-1:0] : rem_shift[swa_pkg::CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/swa_datapath.sv =====
// Datapath: window store, fill count, running total, divider and output
// registers. Depends on swa_pkg and swa_div; driven by swa_ctrl commands.
`default_nettype none
`include "sliding_window_average_defines.svh"

module swa_datapath #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire swa_pkg::swa_cmd_t                 cmd,
    output swa_pkg::swa_sts_t                      sts,
    input  wire logic signed [swa_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [swa_pkg::CNT_W-1:0]         window_size,
    output logic signed [swa_pkg::AVG_W-1:0]       average_q8,
    output logic [swa_pkg::CNT_W-1:0]              samples_held
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_MAX = (1 << swa_pkg::CNT_W) - 1;
    localparam logic [swa_pkg::CNT_W-1:0] WMAX_CNT =
        swa_pkg::CNT_W'((WINDOW_MAX > CNT_MAX) ? CNT_MAX : WINDOW_MAX);

    logic [swa_pkg::SAMPLE_W-1:0]          window_mem [WINDOW_MAX];

    logic [swa_pkg::CNT_W-1:0]             window_size_reg;
    logic [swa_pkg::CNT_W-1:0]             fill_reg;
    logic [AW-1:0]                         oldest_reg;
    logic signed [swa_pkg::SUM_W-1:0]      sum_reg;
    logic signed [swa_pkg::SAMPLE_W-1:0]   sample_reg;
    logic signed [swa_pkg::SAMPLE_W-1:0]   old_reg;
    logic                                  neg_reg;
    logic signed [swa_pkg::AVG_W-1:0]      average_reg;
    logic [swa_pkg::CNT_W-1:0]             held_reg;

    logic [swa_pkg::CNT_W-1:0]             eff_window;
    logic                                  full;
    logic [AW-1:0]                         wr_addr;
    logic [AW-1:0]                         oldest_next;
    logic signed [swa_pkg::SUM_W-1:0]      old_term;
    logic signed [swa_pkg::SUM_W-1:0]      sum_next;
    logic [swa_pkg::SUM_W-1:0]             magnitude;
    logic [swa_pkg::DVD_W-1:0]             dividend;
    logic                                  div_done;
    logic [swa_pkg::DVD_W-1:0]             quotient;
    logic [swa_pkg::AVG_W-1:0]             q_low;

    // zero acts as a window of one; clip to the store depth
    always_comb
    begin
        priority if (window_size_reg == '0)
            eff_window = swa_pkg::CNT_W'(1);
        else if (window_size_reg > WMAX_CNT)
            eff_window = WMAX_CNT;
        else
            eff_window = window_size_reg;
    end

    assign full        = (fill_reg >= eff_window);
    assign wr_addr     = full ? oldest_reg : AW'(fill_reg);
    assign oldest_next = (swa_pkg::CNT_W'(oldest_reg) + 1'b1 == eff_window) ? '0
                                                                          : oldest_reg + 1'b1;
    assign old_term    = full ? swa_pkg::SUM_W'(old_reg) : '0;
    assign sum_next    = sum_reg + swa_pkg::SUM_W'(sample_reg) - old_term;
    assign magnitude   = sum_reg[swa_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    assign dividend    = {magnitude, {swa_pkg::FRAC_W{1'b0}}};
    assign q_low       = quotient[swa_pkg::AVG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swa_pkg::WINDOW_RESET;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            sum_reg         <= '0;
        end
        else if (cmd.cfg_write)
        begin
            window_size_reg <= window_size;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            sum_reg         <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg <= sum_next;
            if (full)
                oldest_reg <= oldest_next;
            else
                fill_reg <= fill_reg + 1'b1;
        end
    end

    // the oldest slot is read as the item is taken, ready for the update cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            old_reg    <= window_mem[oldest_reg];
        end
        if (cmd.update)
            window_mem[wr_addr] <= sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            neg_reg <= sum_reg[swa_pkg::SUM_W-1];
        if (cmd.load_out)
        begin
            average_reg <= neg_reg ? -q_low : q_low;
            held_reg    <= fill_reg;
        end
    end

    swa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.div_done = div_done;
    assign average_q8   = average_reg;
    assign samples_held = held_reg;

    `SWA_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= eff_window, "fill count beyond window")
    `SWA_ASSERT_IMP(a_oldest_filling, !full, oldest_reg == '0, "oldest slot moved while filling")
    `SWA_ASSERT_NXT(a_full_stays, cmd.update && full && !cmd.cfg_write,
                    fill_reg == $past(fill_reg), "full window lost a sample")

endmodule

`default_nettype wire

// ===== hdl/swa_ctrl.sv =====
// Controller state machine: sequences capture, update, divide and output
// load, and owns the channel handshakes. Depends on swa_pkg.
`default_nettype none
`include "sliding_window_average_defines.svh"

module swa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    output swa_pkg::swa_cmd_t      cmd,
    input  wire swa_pkg::swa_sts_t sts
);

    typedef enum logic [2:0] {
        IDLE,
        UPDATE,
        START,
        DIVIDE,
        EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == IDLE);
    // hold off items outside IDLE and while a register write is offered
    assign in_stall  = (state_reg != IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;

    assign cmd.capture   = in_valid && !in_stall;
    assign cmd.cfg_write = cfg_valid && cfg_ready;
    assign cmd.update    = (state_reg == UPDATE);
    assign cmd.div_start = (state_reg == START);
    assign cmd.load_out  = (state_reg == EMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one leaving in the same cycle
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (cmd.capture)
                        state_reg <= UPDATE;
                end
                UPDATE:
                begin
                    state_reg <= START;
                end
                START:
                begin
                    state_reg <= DIVIDE;
                end
                DIVIDE:
                begin
                    if (sts.div_done)
                        state_reg <= EMIT;
                end
                EMIT:
                begin
                    if (out_free)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `SWA_ASSERT_IMP(a_done_in_divide, sts.div_done, state_reg == DIVIDE, "divider done out of turn")
    `SWA_ASSERT_NXT(a_capture_update, cmd.capture, state_reg == UPDATE, "item taken but not updated")
    `SWA_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_reg, "loaded item not presented")

endmodule

`default_nettype wire

// ===== hdl/sliding_window_average.sv =====
// Sliding window average: mean of the most recent window_size samples.
// Input channel: in_valid / in_stall with a signed 32-bit sample; an item
// is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with average_q8 (signed, 8
// fractional bits, truncated toward zero) and samples_held; one result
// per item.
// Configuration: cfg_valid / cfg_ready with window_size; a write empties
// the window. cfg_ready is high only between items.
// Sequence: each taken item is captured and added to the running total;
// the 47-step bit-serial divider then divides the scaled running total by
// the fill count, and the result goes to the output register before the next item is taken.
// A finished result sits in the output register while the next item is
// worked on; if out_stall is still high when the following one is ready,
// the block holds that result and takes no new item until it moves on.
// Reset empties the window, drops any pending result and sets the window
// to 3 samples.
// Depends on swa_pkg, swa_ctrl, swa_datapath and swa_div.
`default_nettype none

module sliding_window_average #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [swa_pkg::SAMPLE_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [swa_pkg::AVG_W-1:0]         average_q8,
    output logic [swa_pkg::CNT_W-1:0]                samples_held,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [swa_pkg::CNT_W-1:0]           window_size
);

    swa_pkg::swa_cmd_t cmd;
    swa_pkg::swa_sts_t sts;

    swa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    swa_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (sample),
        .window_size  (window_size),
        .average_q8   (average_q8),
        .samples_held (samples_held)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sliding_window_average: streams signed samples,
// predicts each mean and fill count in a model of its own, checks every result.
// Depends on swa_pkg and the sliding_window_average RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int          WINDOW_MAX  = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 60;
    localparam int          RANDOM_ITEMS = 400;

    typedef struct packed {
        logic signed [swa_pkg::AVG_W-1:0] avg_q8;
        logic [swa_pkg::CNT_W-1:0]        held;
    } mean_result_t;

    typedef enum {SPREAD, TOP_RAIL, BOTTOM_RAIL} sample_style_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [swa_pkg::SAMPLE_W-1:0] sample;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [swa_pkg::AVG_W-1:0]    average_q8;
    logic [swa_pkg::CNT_W-1:0]           samples_held;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [swa_pkg::CNT_W-1:0]           window_size;

    // prediction state
    logic signed [swa_pkg::SAMPLE_W-1:0] ring_samples [WINDOW_MAX];
    int unsigned                         head_slot;
    int unsigned                         fill_level;
    longint                              window_total;
    logic [swa_pkg::CNT_W-1:0]           window_reg;

    mean_result_t expected_means [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned hold_len;
    bit          quiet_send;
    bit          quiet_recv;

    sliding_window_average #(
        .WINDOW_MAX (WINDOW_MAX)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_q8   (average_q8),
        .samples_held (samples_held),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_size  (window_size)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void empty_window();
        head_slot    = 0;
        fill_level   = 0;
        window_total = 0;
    endfunction

    // Push one sample into the window and return the mean it leaves behind.
    function automatic mean_result_t advance_window(
        logic signed [swa_pkg::SAMPLE_W-1:0] item_value);
        int unsigned  span;
        int unsigned  slot;
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  quot;
        mean_result_t r;
        span = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
        if (fill_level < span)
        begin
            slot = (head_slot + fill_level) % span;
            ring_samples[slot] = item_value;
            window_total += item_value;
            fill_level++;
        end
        else
        begin
            slot = head_slot % span;
            window_total = window_total - ring_samples[slot] + item_value;
            ring_samples[slot] = item_value;
            head_slot = (slot + 1) % span;
            fill_level = span;
        end
        neg  = window_total < 0;
        mag  = neg ? -window_total : window_total;
        quot = (mag << swa_pkg::FRAC_W) / fill_level;
        r.avg_q8 = neg ? -quot[swa_pkg::AVG_W-1:0] : quot[swa_pkg::AVG_W-1:0];
        r.held   = swa_pkg::CNT_W'(fill_level);
        return r;
    endfunction

    function automatic logic signed [swa_pkg::SAMPLE_W-1:0] pick_sample(sample_style_t style);
        case (style)
            TOP_RAIL:    return ($urandom_range(3) == 0) ? 32'sh7fff_ffff
                                                         : {1'b0, 31'($urandom)};
            BOTTOM_RAIL: return ($urandom_range(3) == 0) ? 32'sh8000_0000
                                                         : {1'b1, 31'($urandom)};
            default:
                case ($urandom_range(7))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return 32'($urandom_range(16)) - 32'sd8;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // Offer one item and hold it until taken; valid stays high for a follow-on item.
    task automatic send_sample(logic signed [swa_pkg::SAMPLE_W-1:0] item_value);
        if (!quiet_send && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= item_value;
        do
            @(posedge clk);
        while (in_stall);
        expected_means.insert(expected_means.size(), advance_window(item_value));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(logic [swa_pkg::CNT_W-1:0] value);
        drain();
        cfg_valid   <= 1'b1;
        window_size <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        window_reg = value;
        empty_window();
    endtask

    // Reset window of three: rails, sign changes, then sliding past the fill.
    task automatic test_default_window();
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sd0);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh7fff_ffff);
    endtask

    // Zero acts as one, oversize saturates, and both bounds of the legal range.
    task automatic test_window_limits();
        write_window(7'd0);
        send_sample(32'sd5);
        send_sample(-32'sd7);
        send_sample(32'sh8000_0000);
        write_window(7'd127);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        send_sample(32'sd3);
        send_sample(-32'sd1);
        write_window(7'd1);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample(32'sd0);
        write_window(7'd64);
        send_sample(-32'sd3);
        send_sample(32'sd2);
        send_sample(32'sd0);
        write_window(7'd65);
        send_sample(32'sd1);
        send_sample(32'sd2);
    endtask

    // Receiver holds off while items keep coming, so the block backs up.
    task automatic test_receiver_hold_off();
        write_window(7'd4);
        quiet_send = 1'b1;
        hold_len   = 400;
        repeat (8) send_sample(pick_sample(SPREAD));
        quiet_send = 1'b0;
        drain();
    endtask

    task automatic test_random_windows();
        int unsigned               sent;
        int unsigned               phase;
        int unsigned               span;
        int unsigned               count;
        logic [swa_pkg::CNT_W-1:0] w;
        sample_style_t             style;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:       w = 7'd1;
                1:       w = 7'd64;
                2:       w = 7'($urandom_range(WINDOW_MAX + 1, 127));
                3:       w = 7'd0;
                4:       w = 7'd2;
                default: w = 7'($urandom_range(1, WINDOW_MAX));
            endcase
            write_window(w);
            span  = (w == 0) ? 1 : ((w > WINDOW_MAX) ? WINDOW_MAX : w);
            count = span + $urandom_range(1, 20);
            case ($urandom_range(5))
                0:       style = TOP_RAIL;
                1:       style = BOTTOM_RAIL;
                default: style = SPREAD;
            endcase
            // the second and third window phases run with no idling on either side
            quiet_send = (phase == 1 || phase == 2);
            quiet_recv = quiet_send;
            repeat (count) send_sample(pick_sample(style));
            sent += count;
            phase++;
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            out_stall <= 1'b1;
            hold_len = hold_len - 1;
        end
        else if (quiet_recv)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 30);
    end

    always @(posedge clk)
    begin : check_results
        mean_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: average_q8=%0d samples_held=%0d",
                             average_q8, samples_held);
            end
            else
            begin
                due = expected_means[0];
                expected_means.delete(0);
                if (average_q8 !== due.avg_q8 || samples_held !== due.held)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp avg=%0d held=%0d, got avg=%0d held=%0d",
                                 due.avg_q8, due.held, average_q8, samples_held);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        window_size = swa_pkg::WINDOW_RESET;
        mismatches  = 0;
        cycle_count = 0;
        hold_len    = 0;
        quiet_send  = 1'b0;
        quiet_recv  = 1'b0;
        window_reg  = swa_pkg::WINDOW_RESET;
        empty_window();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_window();
        test_window_limits();
        test_receiver_hold_off();
        test_random_windows();

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
